/* rtl/motion_command_limiter_unit_assert.svh */
// Assertion helpers for the motion command limiter.
// Both macros expect clk and arst_n in scope.
`ifndef MOTION_COMMAND_LIMITER_UNIT_ASSERT_SVH
`define MOTION_COMMAND_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication
`define MCL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mcl_pkg.sv */
package mcl_pkg;

	localparam int VAL_W      = 24;
	localparam int TIME_W     = 32;
	localparam int REQ_W      = 25;
	localparam int REL_W      = 18;
	localparam int FRAC_W     = 17;
	localparam int POS_W      = 26;
	localparam int STEP_W     = 25;
	localparam int PROD_W     = VAL_W + TIME_W;
	localparam int DIVX_W     = 31;
	localparam int RECIP_W    = 32;
	localparam int QUOT_W     = DIVX_W + RECIP_W;
	localparam int RECIP_SH   = 38;
	localparam int SAT_BIT    = 34;
	localparam int RELP_W     = FRAC_W + VAL_W;

	localparam logic [TIME_W-1:0]  UPDATE_INTERVAL_MS = 32'd50;
	localparam logic [FRAC_W-1:0]  REL_ONE            = 17'h10000;
	// ceil(2^38 / 125), exact for 31-bit dividends
	localparam logic [RECIP_W-1:0] RECIP_125          = 32'd2199023256;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_ABS  = 2'd1;
	localparam logic [1:0] ACT_REL  = 2'd2;
	localparam logic [1:0] ACT_SNAP = 2'd3;

	typedef struct packed {
		logic              sat;
		logic [STEP_W-1:0] val;
	} step_t;

	typedef struct packed {
		logic             changed;
		logic [VAL_W-1:0] depth;
		logic [VAL_W-1:0] stroke;
		logic [VAL_W-1:0] len;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] spd;
		logic [VAL_W-1:0] acc;
		logic             crash;
	} res_t;

endpackage

/* rtl/mcl_slew.sv */
module mcl_slew (
	input  logic [mcl_pkg::VAL_W-1:0] cur,
	input  logic [mcl_pkg::VAL_W-1:0] tgt,
	input  mcl_pkg::step_t            step,
	output logic [mcl_pkg::VAL_W-1:0] nxt_val,
	output logic                      moved
);

	logic [mcl_pkg::VAL_W-1:0] delta;

	assign delta = (cur > tgt) ? (cur - tgt) : (tgt - cur);
	assign moved = (cur != tgt);

	always_comb begin
		priority if (!moved) begin
			nxt_val = cur;
		end else if (step.sat || ({1'b0, delta} <= step.val)) begin
			nxt_val = tgt;
		end else if (cur < tgt) begin
			nxt_val = cur + step.val[mcl_pkg::VAL_W-1:0];
		end else begin
			nxt_val = cur - step.val[mcl_pkg::VAL_W-1:0];
		end
	end

endmodule

/* rtl/motion_command_limiter_unit.sv */
// channel   dir  handshake                    payload
// s_*       in   s_tvalid/s_tready            s_tdata (fields), s_tuser (action)
// m_*       out  m_tvalid/m_tready            m_tdata (result fields)
// apb       in   psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One request per cycle sustained while m_tready holds; m_tvalid rises after the request passes
// through the input stage, ease*elapsed multiply, reciprocal divide-by-1000 multiply and slew/clamp
// into the result register. The two multipliers set the depth of the pipe.
// Reset clears config registers, working depth/stroke, last tick time and all valids.
// Each stage advances when the next one is empty or moving, so a stalled result
// still lets up to three more requests in.
`include "motion_command_limiter_unit_assert.svh"

module motion_command_limiter_unit #(
	parameter logic [mcl_pkg::TIME_W-1:0] UPDATE_INTERVAL_MS = mcl_pkg::UPDATE_INTERVAL_MS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] now_ms, [56:32] stroke_request, [74:57] relative_position,
	// [99:75] speed_request, [124:100] accel_request, [125] motion_done,
	// [149:126] motor_accel, [151:150] zero
	input  logic [151:0] s_tdata,
	// [1:0] action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] changed, [24:1] current_depth, [48:25] current_stroke,
	// [72:49] stroke_length, [98:73] target_position, [122:99] safe_speed,
	// [146:123] safe_accel, [147] crash_avoided, [151:148] zero
	output logic [151:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam logic [2:0] REG_TGT_DEPTH  = 3'd0;
	localparam logic [2:0] REG_TGT_STROKE = 3'd1;
	localparam logic [2:0] REG_DEPTH_LIM  = 3'd2;
	localparam logic [2:0] REG_STROKE_LIM = 3'd3;
	localparam logic [2:0] REG_VEL_LIM    = 3'd4;
	localparam logic [2:0] REG_EASE       = 3'd5;
	localparam logic [2:0] REG_MAX_ACC    = 3'd6;

	localparam int VW = mcl_pkg::VAL_W;

	// config
	logic [VW-1:0] tgt_depth_q, tgt_stroke_q, depth_lim_q, stroke_lim_q;
	logic [VW-1:0] vel_lim_q, ease_q, max_acc_q;
	logic          cfg_wr;

	// state
	logic [VW-1:0]               depth_q, stroke_q;
	logic [mcl_pkg::TIME_W-1:0]  last_q;

	// stage 1
	logic                        v1_s1;
	logic [1:0]                  act_s1;
	logic [mcl_pkg::TIME_W-1:0]  now_s1;
	logic [mcl_pkg::REQ_W-1:0]   sreq_s1, spdreq_s1, accreq_s1;
	logic [mcl_pkg::REL_W-1:0]   rel_s1;
	logic                        done_s1;
	logic [VW-1:0]               macc_s1;

	// stage 2
	logic                        v2_s2, perform_s2, crash_s2;
	logic [1:0]                  act_s2;
	logic [mcl_pkg::PROD_W-1:0]  prod_s2;
	logic [VW-1:0]               spd_s2, acc_s2, sreq_s2;
	logic [mcl_pkg::FRAC_W-1:0]  frac_s2;

	// stage 3
	logic                        v3_s3, perform_s3, crash_s3, sat_s3;
	logic [1:0]                  act_s3;
	logic [mcl_pkg::QUOT_W-1:0]  quot_s3;
	logic [VW-1:0]               spd_s3, acc_s3, sreq_s3;
	logic [mcl_pkg::FRAC_W-1:0]  frac_s3;

	// output
	logic          out_v_q;
	mcl_pkg::res_t res_q, res_d;

	logic rdy_out, rdy3, rdy2, adv2, adv3, fire3;

	// stage 1 logic
	logic [mcl_pkg::TIME_W-1:0]  elapsed;
	logic                        perform_s1;
	logic [VW-1:0]               ease, spd_c, acc_c, sreq_c, acc_clamp;
	logic [mcl_pkg::FRAC_W-1:0]  frac_c;
	logic                        crash_c;
	logic [mcl_pkg::PROD_W-1:0]  prod_c;

	// stage 2 logic
	logic                        sat_c;
	logic [mcl_pkg::QUOT_W-1:0]  quot_c;

	// stage 3 logic
	logic [VW-1:0]               tgt_d, tgt_s, nxt_d, nxt_s, len_c, rel_len;
	logic                        moved_d, moved_s;
	mcl_pkg::step_t              step;
	logic [mcl_pkg::RELP_W-1:0]  rel_prod;
	logic [mcl_pkg::STEP_W-1:0]  rel_q;
	logic [mcl_pkg::POS_W-1:0]   pos_c;

	// handshake chain
	assign rdy_out  = !out_v_q || m_tready;
	assign rdy3     = !v3_s3 || rdy_out;
	assign rdy2     = !v2_s2 || rdy3;
	assign s_tready = !v1_s1 || rdy2;
	assign adv2     = v1_s1 && rdy2;
	assign adv3     = v2_s2 && rdy3;
	assign fire3    = v3_s3 && rdy_out;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_depth_q  <= '0;
			tgt_stroke_q <= '0;
			depth_lim_q  <= '0;
			stroke_lim_q <= '0;
			vel_lim_q    <= '0;
			ease_q       <= '0;
			max_acc_q    <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_TGT_DEPTH:  tgt_depth_q  <= pwdata[VW-1:0];
				REG_TGT_STROKE: tgt_stroke_q <= pwdata[VW-1:0];
				REG_DEPTH_LIM:  depth_lim_q  <= pwdata[VW-1:0];
				REG_STROKE_LIM: stroke_lim_q <= pwdata[VW-1:0];
				REG_VEL_LIM:    vel_lim_q    <= pwdata[VW-1:0];
				REG_EASE:       ease_q       <= pwdata[VW-1:0];
				REG_MAX_ACC:    max_acc_q    <= pwdata[VW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_TGT_DEPTH:  prdata = {8'b0, tgt_depth_q};
			REG_TGT_STROKE: prdata = {8'b0, tgt_stroke_q};
			REG_DEPTH_LIM:  prdata = {8'b0, depth_lim_q};
			REG_STROKE_LIM: prdata = {8'b0, stroke_lim_q};
			REG_VEL_LIM:    prdata = {8'b0, vel_lim_q};
			REG_EASE:       prdata = {8'b0, ease_q};
			REG_MAX_ACC:    prdata = {8'b0, max_acc_q};
			default:        prdata = '0;
		endcase
	end

	// stage 1: capture request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (s_tready) begin
			v1_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1    <= s_tuser;
			now_s1    <= s_tdata[31:0];
			sreq_s1   <= s_tdata[56:32];
			rel_s1    <= s_tdata[74:57];
			spdreq_s1 <= s_tdata[99:75];
			accreq_s1 <= s_tdata[124:100];
			done_s1   <= s_tdata[125];
			macc_s1   <= s_tdata[149:126];
		end
	end

	assign elapsed    = now_s1 - last_q;
	assign perform_s1 = (act_s1 == mcl_pkg::ACT_TICK) && (elapsed >= UPDATE_INTERVAL_MS);
	assign ease       = (ease_q < vel_lim_q) ? ease_q : vel_lim_q;
	assign prod_c     = mcl_pkg::PROD_W'(ease) * mcl_pkg::PROD_W'(elapsed);

	assign spd_c = spdreq_s1[mcl_pkg::REQ_W-1] ? '0 :
		((spdreq_s1[VW-1:0] > vel_lim_q) ? vel_lim_q : spdreq_s1[VW-1:0]);
	assign acc_clamp = accreq_s1[mcl_pkg::REQ_W-1] ? '0 :
		((accreq_s1[VW-1:0] > max_acc_q) ? max_acc_q : accreq_s1[VW-1:0]);
	assign crash_c = !done_s1 &&
		($signed({2'b00, macc_s1}) > $signed({accreq_s1[mcl_pkg::REQ_W-1], accreq_s1}));
	assign acc_c  = crash_c ? macc_s1 : acc_clamp;
	assign sreq_c = sreq_s1[mcl_pkg::REQ_W-1] ? '0 : sreq_s1[VW-1:0];
	assign frac_c = rel_s1[mcl_pkg::REL_W-1] ? '0 :
		((rel_s1[mcl_pkg::FRAC_W-1:0] > mcl_pkg::REL_ONE) ? mcl_pkg::REL_ONE :
		rel_s1[mcl_pkg::FRAC_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			v2_s2  <= 1'b0;
		end else begin
			if (adv2 && perform_s1) begin
				last_q <= now_s1;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			act_s2     <= act_s1;
			perform_s2 <= perform_s1;
			prod_s2    <= prod_c;
			spd_s2     <= spd_c;
			acc_s2     <= acc_c;
			crash_s2   <= crash_c;
			sreq_s2    <= sreq_c;
			frac_s2    <= frac_c;
		end
	end

	// stage 2: floor(P/1000) = floor(floor(P/8)/125); large products snap outright
	assign sat_c  = |prod_s2[mcl_pkg::PROD_W-1:mcl_pkg::SAT_BIT];
	assign quot_c = mcl_pkg::QUOT_W'(prod_s2[mcl_pkg::SAT_BIT-1:3]) *
		mcl_pkg::QUOT_W'(mcl_pkg::RECIP_125);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (rdy3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			act_s3     <= act_s2;
			perform_s3 <= perform_s2;
			sat_s3     <= sat_c;
			quot_s3    <= quot_c;
			spd_s3     <= spd_s2;
			acc_s3     <= acc_s2;
			crash_s3   <= crash_s2;
			sreq_s3    <= sreq_s2;
			frac_s3    <= frac_s2;
		end
	end

	// stage 3: slew, command position, result
	assign tgt_d    = (tgt_depth_q < depth_lim_q) ? tgt_depth_q : depth_lim_q;
	assign tgt_s    = (tgt_stroke_q < stroke_lim_q) ? tgt_stroke_q : stroke_lim_q;
	assign step.sat = sat_s3;
	assign step.val = quot_s3[mcl_pkg::RECIP_SH +: mcl_pkg::STEP_W];

	mcl_slew u_slew_depth (
		.cur     (depth_q),
		.tgt     (tgt_d),
		.step    (step),
		.nxt_val (nxt_d),
		.moved   (moved_d)
	);

	mcl_slew u_slew_stroke (
		.cur     (stroke_q),
		.tgt     (tgt_s),
		.step    (step),
		.nxt_val (nxt_s),
		.moved   (moved_s)
	);

	assign rel_prod = mcl_pkg::RELP_W'(frac_s3) * mcl_pkg::RELP_W'(stroke_q);
	assign rel_q    = rel_prod[16 +: mcl_pkg::STEP_W];
	assign rel_len  = (rel_q > {1'b0, stroke_q}) ? stroke_q : rel_q[VW-1:0];
	assign len_c    = (act_s3 == mcl_pkg::ACT_ABS) ?
		((sreq_s3 > stroke_q) ? stroke_q : sreq_s3) : rel_len;
	assign pos_c    = {2'b00, depth_q} - {2'b00, stroke_q} + {2'b00, len_c};

	always_comb begin
		res_d = '0;
		unique case (act_s3)
			mcl_pkg::ACT_TICK: begin
				res_d.depth  = perform_s3 ? nxt_d : depth_q;
				res_d.stroke = perform_s3 ? nxt_s : stroke_q;
				res_d.changed = perform_s3 && (moved_d || moved_s);
			end
			mcl_pkg::ACT_SNAP: begin
				res_d.depth  = tgt_d;
				res_d.stroke = tgt_s;
			end
			mcl_pkg::ACT_ABS, mcl_pkg::ACT_REL: begin
				res_d.depth  = depth_q;
				res_d.stroke = stroke_q;
				res_d.len    = len_c;
				res_d.pos    = pos_c;
				res_d.spd    = spd_s3;
				res_d.acc    = acc_s3;
				res_d.crash  = crash_s3;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			stroke_q <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (fire3) begin
				depth_q  <= res_d.depth;
				stroke_q <= res_d.stroke;
			end
			if (rdy_out) begin
				out_v_q <= v3_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire3) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'b0000, res_q.crash, res_q.acc, res_q.spd, res_q.pos, res_q.len,
		res_q.stroke, res_q.depth, res_q.changed};

	`MCL_ASSERT_NXT(a_early_tick_keeps_time, adv2 && !perform_s1, $stable(last_q), "last tick time moved without a performed tick")
	`MCL_ASSERT_NXT(a_changed_only_on_tick, fire3 && (act_s3 != mcl_pkg::ACT_TICK), !res_q.changed, "changed set on a non-tick request")
	`MCL_ASSERT_NXT(a_sat_step_lands, fire3 && perform_s3 && sat_s3, (depth_q == $past(tgt_d)) && (stroke_q == $past(tgt_s)), "saturated step did not reach targets")
	`MCL_ASSERT_IMP(a_full_when_blocked, !s_tready, v1_s1 && v2_s2 && v3_s3 && out_v_q, "input blocked while pipe has room")

endmodule
